@@ rtl/ppc_pkg.sv @@
`default_nettype none

package ppc_pkg;

  localparam int unsigned MAX_PERIODS = 1024;
  localparam int unsigned TS_W        = 16;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam int unsigned COUNT_MAX_I = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(COUNT_MAX_I);
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    COUNT_W'((MAX_PERIODS > COUNT_MAX_I) ? COUNT_MAX_I : MAX_PERIODS);

  localparam logic [COUNT_W-1:0] TARGET_RESET     = COUNT_W'(5);
  localparam logic [TOTAL_W-1:0] TIME_LIMIT_RESET = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIODS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT     = 1'b1;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t              run_phase;
    logic                edge_was_falling;
    logic                record_valid;
    logic [INDEX_W-1:0]  period_index;
    logic [TS_W-1:0]     high_ticks;
    logic [TS_W-1:0]     low_ticks;
    logic [COUNT_W-1:0]  period_count;
    logic [TOTAL_W-1:0]  total_ticks;
    logic                run_done;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/ppc_core.sv @@
`default_nettype none

module ppc_core
  import ppc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic                cmd,
  input  wire logic [TS_W-1:0]     timestamp,
  input  wire logic [COUNT_W-1:0]  target_periods,
  input  wire logic [TOTAL_W-1:0]  time_limit,
  output result_t                  res
);

  phase_t              phase_r, phase_nxt;
  logic                expect_falling_r, expect_falling_nxt;
  logic [TS_W-1:0]     last_stamp_r, last_stamp_nxt;
  logic [TS_W-1:0]     held_high_r, held_high_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic                is_arm, is_rise, is_fall, closes_period;
  logic [TS_W-1:0]     elapsed;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_sat;
  logic [COUNT_W-1:0]  count_inc;
  logic                stop;

  assign is_arm  = (cmd == CMD_ARM);
  assign is_rise = !is_arm && !expect_falling_r;
  assign is_fall = !is_arm && expect_falling_r;
  assign closes_period = is_rise && (phase_r == PH_RUN);

  // Timer wraps at 2^16, so a plain truncated difference is the elapsed time.
  assign elapsed   = timestamp - last_stamp_r;
  assign sum       = {1'b0, total_r} + (TOTAL_W+1)'(held_high_r) + (TOTAL_W+1)'(elapsed);
  assign total_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign count_inc = (count_r < COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
  assign stop      = (count_inc >= COUNT_CAP) || (count_inc >= target_periods) ||
                     (total_sat >= time_limit);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (is_arm) begin
      phase_nxt = PH_WAIT;
    end else if (is_rise) begin
      unique case (phase_r)
        PH_WAIT: phase_nxt = PH_RUN;
        PH_RUN:  phase_nxt = stop ? PH_IDLE : PH_RUN;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Measurement datapath.
  always_comb begin
    expect_falling_nxt = is_arm ? expect_falling_r : !expect_falling_r;
    last_stamp_nxt     = last_stamp_r;
    held_high_nxt      = held_high_r;
    count_nxt          = count_r;
    total_nxt          = total_r;
    if (is_rise && (phase_r == PH_WAIT)) begin
      last_stamp_nxt = timestamp;
      count_nxt      = '0;
      total_nxt      = '0;
    end else if (closes_period) begin
      last_stamp_nxt = timestamp;
      count_nxt      = count_inc;
      total_nxt      = total_sat;
    end else if (is_fall && (phase_r == PH_RUN)) begin
      held_high_nxt  = elapsed;
      last_stamp_nxt = timestamp;
    end
  end

  // Result beat for this item.
  always_comb begin
    res                  = '0;
    res.run_phase        = phase_nxt;
    res.edge_was_falling = is_fall;
    res.record_valid     = closes_period;
    res.period_count     = count_nxt;
    res.total_ticks      = total_nxt;
    res.run_done         = closes_period && stop;
    if (closes_period) begin
      res.period_index = count_r[INDEX_W-1:0];
      res.high_ticks   = held_high_r;
      res.low_ticks    = elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      expect_falling_r <= 1'b0;
      last_stamp_r     <= '0;
      held_high_r      <= '0;
      count_r          <= '0;
      total_r          <= '0;
    end else if (fire) begin
      phase_r          <= phase_nxt;
      expect_falling_r <= expect_falling_nxt;
      last_stamp_r     <= last_stamp_nxt;
      held_high_r      <= held_high_nxt;
      count_r          <= count_nxt;
      total_r          <= total_nxt;
    end
  end

`ifndef SYNTH
  a_rise_flips_polarity: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_rise |=> expect_falling_r)
    else $error("polarity did not flip to falling after a rising edge");

  a_arm_waits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_arm |=> phase_r == PH_WAIT)
    else $error("arm command did not enter waiting");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_rise && phase_r == PH_WAIT |=> count_r == '0 && total_r == '0)
    else $error("run start did not clear count and total");

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res.run_done |-> res.record_valid && res.run_phase == PH_IDLE)
    else $error("run ended without a period record or without going idle");
`endif

endmodule

`default_nettype wire

@@ rtl/pulse_period_capture_top.sv @@
// Pulse period capture: each input beat is an arm command or a pin edge with
// its 16-bit timer stamp, and each beat yields exactly one result beat with
// the run phase, the period record (high and low time) when a rising edge
// closes a period, and the running period count and total time. Throughput
// is one beat per clock while out_stall stays low, set by the single-pass
// period logic; each result passes through one input register, then the
// period logic into the result register. While a result waits on
// out_stall the input register still takes one more beat, after which
// in_stall holds the input side. Configuration writes take effect on the
// next clock and must only be issued while the block is idle.
`default_nettype none

module pulse_period_capture_top
  import ppc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_cmd,
  input  wire logic [TS_W-1:0]       in_timestamp,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_run_phase,
  output logic                       out_edge_was_falling,
  output logic                       out_record_valid,
  output logic [INDEX_W-1:0]         out_period_index,
  output logic [TS_W-1:0]            out_high_ticks,
  output logic [TS_W-1:0]            out_low_ticks,
  output logic [COUNT_W-1:0]         out_period_count,
  output logic [TOTAL_W-1:0]         out_total_ticks,
  output logic                       out_run_done
);

  logic [COUNT_W-1:0]  target_periods_r;
  logic [TOTAL_W-1:0]  time_limit_r;

  logic                in_full_r, in_full_nxt;
  logic                in_cmd_r;
  logic [TS_W-1:0]     in_ts_r;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_res_r;
  result_t             res;

  logic                in_take, advance;

  // The held beat moves on whenever the result register is free or drains.
  assign advance     = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall    = in_full_r && !advance;
  assign in_take     = in_valid && !in_stall;
  assign in_full_nxt = in_take || (in_full_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_periods_r <= TARGET_RESET;
      time_limit_r     <= TIME_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_PERIODS: target_periods_r <= cfg_wdata[COUNT_W-1:0];
        CFG_TIME_LIMIT:     time_limit_r     <= cfg_wdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r <= in_cmd;
      in_ts_r  <= in_timestamp;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  ppc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (advance),
    .cmd            (in_cmd_r),
    .timestamp      (in_ts_r),
    .target_periods (target_periods_r),
    .time_limit     (time_limit_r),
    .res            (res)
  );

  assign out_valid            = out_valid_r;
  assign out_run_phase        = out_res_r.run_phase;
  assign out_edge_was_falling = out_res_r.edge_was_falling;
  assign out_record_valid     = out_res_r.record_valid;
  assign out_period_index     = out_res_r.period_index;
  assign out_high_ticks       = out_res_r.high_ticks;
  assign out_low_ticks        = out_res_r.low_ticks;
  assign out_period_count     = out_res_r.period_count;
  assign out_total_ticks      = out_res_r.total_ticks;
  assign out_run_done         = out_res_r.run_done;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench
  import ppc_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_ROWS    = 20;

  typedef struct {
    logic            cmd;
    logic [TS_W-1:0] ts;
    bit              typed;
    phase_t          ph;
    logic            fall;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [TS_W-1:0]       in_timestamp;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_run_phase;
  logic                  out_edge_was_falling;
  logic                  out_record_valid;
  logic [INDEX_W-1:0]    out_period_index;
  logic [TS_W-1:0]       out_high_ticks;
  logic [TS_W-1:0]       out_low_ticks;
  logic [COUNT_W-1:0]    out_period_count;
  logic [TOTAL_W-1:0]    out_total_ticks;
  logic                  out_run_done;

  // Shadow copy of the capture state and registers.
  phase_t              st_phase;
  logic                st_want_fall;
  logic [TS_W-1:0]     st_last;
  logic [TS_W-1:0]     st_high;
  logic [COUNT_W-1:0]  st_count;
  logic [TOTAL_W-1:0]  st_total;
  logic [COUNT_W-1:0]  st_target;
  logic [TOTAL_W-1:0]  st_limit;

  result_t   expected_results[$];
  stim_row_t dir_rows[DIR_ROWS];
  logic [TS_W-1:0] timer;
  bit        steady;
  int        mismatches = 0;
  int        beats_sent;
  int        records_seen = 0;
  int        runs_done = 0;
  int        settings_used;
  int        cycle_count = 0;

  pulse_period_capture_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_timestamp         (in_timestamp),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_run_phase        (out_run_phase),
    .out_edge_was_falling (out_edge_was_falling),
    .out_record_valid     (out_record_valid),
    .out_period_index     (out_period_index),
    .out_high_ticks       (out_high_ticks),
    .out_low_ticks        (out_low_ticks),
    .out_period_count     (out_period_count),
    .out_total_ticks      (out_total_ticks),
    .out_run_done         (out_run_done)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic result_t predict_capture(logic cmd, logic [TS_W-1:0] ts);
    result_t         r;
    logic [TS_W-1:0] lo_span;
    logic [TOTAL_W:0] sum;
    r = '0;
    if (cmd == CMD_ARM) begin
      st_phase = PH_WAIT;
    end else if (!st_want_fall) begin
      if (st_phase == PH_WAIT) begin
        st_last  = ts;
        st_count = '0;
        st_total = '0;
        st_phase = PH_RUN;
      end else if (st_phase == PH_RUN) begin
        lo_span = ts - st_last;
        st_last = ts;
        r.record_valid = 1'b1;
        r.period_index = st_count[INDEX_W-1:0];
        r.high_ticks = st_high;
        r.low_ticks = lo_span;
        sum = {1'b0, st_total} + (TOTAL_W+1)'(st_high) + (TOTAL_W+1)'(lo_span);
        st_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        if (st_count != COUNT_MAX) st_count = st_count + 1'b1;
        if (st_count >= COUNT_CAP || st_count >= st_target || st_total >= st_limit) begin
          st_phase = PH_IDLE;
          r.run_done = 1'b1;
        end
      end
      st_want_fall = 1'b1;
    end else begin
      r.edge_was_falling = 1'b1;
      if (st_phase == PH_RUN) begin
        st_high = ts - st_last;
        st_last = ts;
      end
      st_want_fall = 1'b0;
    end
    r.run_phase = st_phase;
    r.period_count = st_count;
    r.total_ticks = st_total;
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic cmd, logic [TS_W-1:0] ts, bit typed,
                                       phase_t ph, logic fall);
    stim_row_t row;
    row.cmd = cmd;
    row.ts = ts;
    row.typed = typed;
    row.ph = ph;
    row.fall = fall;
    return row;
  endfunction

  // Mostly a timer creeping forward, sometimes a near-full wrap or a wild value.
  function automatic logic [TS_W-1:0] next_stamp();
    case ($urandom_range(0, 9))
      0: timer = TS_W'($urandom);
      1: timer = timer + TS_W'($urandom_range(20000, 65535));
      default: timer = timer + TS_W'($urandom_range(1, 400));
    endcase
    return timer;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_beat(logic cmd, logic [TS_W-1:0] ts, bit typed = 1'b0,
                           phase_t ph = PH_IDLE, logic fall = 1'b0);
    int      gap;
    result_t pred;
    result_t want;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_timestamp <= ts;
    do @(posedge clk); while (in_stall);
    pred = predict_capture(cmd, ts);
    if (typed) begin
      want = '0;
      want.run_phase = ph;
      want.edge_was_falling = fall;
    end else begin
      want = pred;
    end
    expected_results.push_back(want);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // Let beats clear the input and result registers before touching registers.
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] target_word,
                              logic [CFG_DATA_W-1:0] limit_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TARGET_PERIODS;
    cfg_wdata <= target_word;
    @(posedge clk);
    cfg_index <= CFG_TIME_LIMIT;
    cfg_wdata <= limit_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    st_target = target_word[COUNT_W-1:0];
    st_limit = limit_word;
    settings_used++;
  endtask

  // Edges that arrive while idle are not counted toward the stretch length.
  task automatic random_stretch(int n_beats);
    int  useful;
    bit  arm;
    useful = 0;
    steady = ($urandom_range(0, 3) == 0);
    while (useful < n_beats) begin
      if (st_phase == PH_IDLE) arm = ($urandom_range(0, 3) != 0);
      else arm = ($urandom_range(0, 39) == 0);
      if (arm || st_phase != PH_IDLE) useful++;
      if (arm) send_beat(CMD_ARM, TS_W'($urandom));
      else send_beat(CMD_EDGE, next_stamp());
    end
    drain();
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_record_valid) records_seen++;
      if (out_run_done) runs_done++;
      if (expected_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("run_phase", 32'(want.run_phase), 32'(out_run_phase));
        check_field("edge_was_falling", 32'(want.edge_was_falling),
                    32'(out_edge_was_falling));
        check_field("record_valid", 32'(want.record_valid), 32'(out_record_valid));
        check_field("period_index", 32'(want.period_index), 32'(out_period_index));
        check_field("high_ticks", 32'(want.high_ticks), 32'(out_high_ticks));
        check_field("low_ticks", 32'(want.low_ticks), 32'(out_low_ticks));
        check_field("period_count", 32'(want.period_count), 32'(out_period_count));
        check_field("total_ticks", want.total_ticks, out_total_ticks);
        check_field("run_done", 32'(want.run_done), 32'(out_run_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] word;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_timestamp = '0;
    steady = 1'b0;
    timer = '0;
    beats_sent = 0;
    settings_used = 0;
    st_phase = PH_IDLE;
    st_want_fall = 1'b0;
    st_last = '0;
    st_high = '0;
    st_count = '0;
    st_total = '0;
    st_target = TARGET_RESET;
    st_limit = TIME_LIMIT_RESET;

    // Reset registers: five periods per run, no time limit.
    dir_rows[0]  = mk_row(CMD_EDGE, 16'h0000, 1'b1, PH_IDLE, 1'b0); // idle edges only toggle
    dir_rows[1]  = mk_row(CMD_EDGE, 16'hFFFF, 1'b1, PH_IDLE, 1'b1);
    dir_rows[2]  = mk_row(CMD_ARM,  16'h1234, 1'b1, PH_WAIT, 1'b0);
    dir_rows[3]  = mk_row(CMD_EDGE, 16'hFFFF, 1'b1, PH_RUN,  1'b0); // run starts, clears sums
    dir_rows[4]  = mk_row(CMD_EDGE, 16'h000F, 1'b0, PH_IDLE, 1'b0); // high time wraps
    dir_rows[5]  = mk_row(CMD_EDGE, 16'h0020, 1'b0, PH_IDLE, 1'b0);
    dir_rows[6]  = mk_row(CMD_ARM,  16'h0000, 1'b0, PH_IDLE, 1'b0); // re-arm keeps sums
    dir_rows[7]  = mk_row(CMD_EDGE, 16'h5555, 1'b0, PH_IDLE, 1'b0); // falling while waiting
    dir_rows[8]  = mk_row(CMD_EDGE, 16'h8000, 1'b1, PH_RUN,  1'b0);
    dir_rows[9]  = mk_row(CMD_EDGE, 16'h7FFF, 1'b0, PH_IDLE, 1'b0); // largest high time
    dir_rows[10] = mk_row(CMD_EDGE, 16'h7FFF, 1'b0, PH_IDLE, 1'b0); // zero low time
    dir_rows[11] = mk_row(CMD_EDGE, 16'h7FFF, 1'b0, PH_IDLE, 1'b0);
    dir_rows[12] = mk_row(CMD_EDGE, 16'hFFFF, 1'b0, PH_IDLE, 1'b0);
    dir_rows[13] = mk_row(CMD_EDGE, 16'h0000, 1'b0, PH_IDLE, 1'b0);
    dir_rows[14] = mk_row(CMD_EDGE, 16'hAAAA, 1'b0, PH_IDLE, 1'b0);
    dir_rows[15] = mk_row(CMD_EDGE, 16'hAAAB, 1'b0, PH_IDLE, 1'b0);
    dir_rows[16] = mk_row(CMD_EDGE, 16'h0001, 1'b0, PH_IDLE, 1'b0);
    dir_rows[17] = mk_row(CMD_EDGE, 16'h1000, 1'b0, PH_IDLE, 1'b0);
    dir_rows[18] = mk_row(CMD_EDGE, 16'hFFFE, 1'b0, PH_IDLE, 1'b0); // fifth period ends run
    dir_rows[19] = mk_row(CMD_EDGE, 16'h4321, 1'b0, PH_IDLE, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].ts, dir_rows[i].typed,
                dir_rows[i].ph, dir_rows[i].fall);
    drain();

    // Zero target: every run stops after its first period.
    word = $urandom;
    word[COUNT_W-1:0] = '0;
    program_regs(word, '1);
    random_stretch(150);

    // Zero time limit stops the run at the first period as well.
    program_regs(32'd3, '0);
    random_stretch(150);

    repeat (8) begin
      word = $urandom;
      word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 12));
      program_regs(word, ($urandom_range(0, 2) == 0) ? $urandom
                                                     : 32'($urandom_range(200, 200000)));
      random_stretch(130);
    end

    drain();
    $display("Drove %0d beats (%0d directed) across %0d register settings.",
             beats_sent, DIR_ROWS, settings_used);
    $display("Checked %0d period records and %0d completed runs.",
             records_seen, runs_done);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ppc_pkg.sv
rtl/ppc_core.sv
rtl/pulse_period_capture_top.sv
sim/testbench.sv
